### sv/gtrc_pkg.sv
// shared constants for the grey to rgb colormap
package gtrc_pkg;

    localparam int GREY_W      = 16;
    localparam int COL_W       = 16;
    localparam int CFG_W       = 5;
    localparam int IDX_IN_W    = 4;
    localparam int MAX_POINTS_DEF = 16;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    // fraction divider: one quotient bit per stage plus an input stage
    localparam int DIV_STEPS  = 16;
    localparam int FRAC_LAT   = DIV_STEPS + 1;

    // channel: five arithmetic stages, then the root pipeline
    localparam int ROOT_STEPS = 17;
    localparam int CHAN_LAT   = 5 + ROOT_STEPS + 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

endpackage

### sv/gtrc_frac.sv
// pipelined fraction divider: floor(65535*offset/span), saturated at 65535
module gtrc_frac (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_offset,
    input  logic [15:0] i_span,
    output logic [15:0] o_frac
);

    localparam int N = gtrc_pkg::DIV_STEPS;

    logic [15:0] r_rem  [0:N];
    logic [15:0] r_low  [0:N];
    logic [15:0] r_quo  [0:N];
    logic [15:0] r_span [0:N];
    logic        r_sat  [0:N];

    logic [31:0] n_dividend;

    assign n_dividend = {i_offset, 16'h0000} - {16'h0000, i_offset};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_dividend[31:16];
            r_low[0]  <= n_dividend[15:0];
            r_quo[0]  <= '0;
            r_span[0] <= i_span;
            r_sat[0]  <= (i_offset >= i_span);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [16:0] n_shift;
        logic        n_ge;
        logic [16:0] n_diff;

        assign n_shift = {r_rem[k], r_low[k][15]};
        assign n_ge    = (n_shift >= {1'b0, r_span[k]});
        assign n_diff  = n_shift - {1'b0, r_span[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? n_diff[15:0] : n_shift[15:0];
                r_low[k+1]  <= {r_low[k][14:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][14:0], n_ge};
                r_span[k+1] <= r_span[k];
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    assign o_frac = r_sat[N] ? gtrc_pkg::FULL_SCALE : r_quo[N];

endmodule

### sv/gtrc_chan.sv
// one colour channel: weighted squares, divide by 65535, pipelined square root
module gtrc_chan (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_col_a,
    input  logic [15:0] i_col_b,
    input  logic [15:0] i_frac,
    output logic [15:0] o_col
);

    localparam int N = gtrc_pkg::ROOT_STEPS;

    logic [32:0] r_sqa, r_sqb;
    logic [15:0] r_f, r_wf;
    logic [48:0] r_pa, r_pb;
    logic [47:0] r_num;
    logic [31:0] r_q1;
    logic [32:0] r_t1;
    logic [32:0] r_q2;
    logic [17:0] r_t2;

    logic [18:0] r_root_rem [0:N];
    logic [16:0] r_root_y   [0:N];
    logic [33:0] r_root_rad [0:N];

    logic [16:0] n_a1, n_b1;
    logic [16:0] n_t3;
    logic [32:0] n_q;

    assign n_a1 = {1'b0, i_col_a} + 17'd1;
    assign n_b1 = {1'b0, i_col_b} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squares of the control colours
            r_sqa <= {16'h0000, n_a1} * {16'h0000, n_a1};
            r_sqb <= {16'h0000, n_b1} * {16'h0000, n_b1};
            r_f   <= i_frac;
            r_wf  <= ~i_frac;
            // weights
            r_pa  <= {33'h0, r_wf} * {16'h0000, r_sqa};
            r_pb  <= {33'h0, r_f}  * {16'h0000, r_sqb};
            r_num <= r_pa[47:0] + r_pb[47:0];
            // divide by 65535 by folding the high half onto the low half
            r_q1  <= r_num[47:16];
            r_t1  <= {1'b0, r_num[47:16]} + {17'h0, r_num[15:0]};
            r_q2  <= {1'b0, r_q1} + {16'h0, r_t1[32:16]};
            r_t2  <= {1'b0, r_t1[32:16]} + {2'b00, r_t1[15:0]};
        end
    end

    assign n_t3 = {15'h0, r_t2[17:16]} + {1'b0, r_t2[15:0]};
    assign n_q  = r_q2 + {31'h0, r_t2[17:16]}
                  + {32'h0, (n_t3 >= {1'b0, gtrc_pkg::FULL_SCALE})};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root_rem[0] <= '0;
            r_root_y[0]   <= '0;
            r_root_rad[0] <= {1'b0, n_q};
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < N; k++) begin : g_root
        logic [20:0] n_shift;
        logic [20:0] n_trial;
        logic        n_ge;
        logic [20:0] n_diff;

        assign n_shift = {r_root_rem[k], r_root_rad[k][33:32]};
        assign n_trial = {2'b00, r_root_y[k], 2'b01};
        assign n_ge    = (n_shift >= n_trial);
        assign n_diff  = n_shift - n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root_rem[k+1] <= n_ge ? n_diff[18:0] : n_shift[18:0];
                r_root_y[k+1]   <= {r_root_y[k][15:0], n_ge};
                r_root_rad[k+1] <= {r_root_rad[k][31:0], 2'b00};
            end
        end
    end

    logic [16:0] n_out;
    assign n_out = r_root_y[N] - 17'd1;
    assign o_col = n_out[15:0];

endmodule

### sv/grey_to_rgb_colormap.sv
// top level: grey to rgb colormap with quadratic interpolation
// throughput: one transfer per cycle while no untaken result holds the pipeline; loads give no result
// the depth is set by the 16-stage fraction divider and the 17-stage root
// the whole pipeline advances together and holds while the result is not taken
// reset (synchronous, active low) clears valid bits and sets points_in_use to 2;
// the tables are not cleared and hold nothing meaningful until loaded
module grey_to_rgb_colormap #(
    parameter int MAX_POINTS = gtrc_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: points_in_use
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index[3:0], entry_breakpoint[19:4], entry_red[35:20],
    // entry_green[51:36], entry_blue[67:52], grey_level[83:68], zero fill
    input  logic [87:0] i_s_axis_tdata,
    // opcode
    input  logic        i_s_axis_tuser,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    output logic [47:0] o_m_axis_tdata,
    // out_of_range
    output logic        o_m_axis_tuser
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int FLAT  = gtrc_pkg::FRAC_LAT;
    localparam int CLAT  = gtrc_pkg::CHAN_LAT;
    localparam int LAST  = 1 + FLAT + CLAT;

    // table storage
    logic [15:0] r_bp  [0:MAX_POINTS-1];
    logic [47:0] r_col [0:MAX_POINTS-1];
    logic [4:0]  r_points;

    // pipeline valid bits, one per stage
    logic        r_vld [0:LAST];
    logic        n_en;

    // input field unpacking
    logic [3:0]  n_in_idx;
    logic [15:0] n_in_bp;
    logic [47:0] n_in_col;
    logic [15:0] n_in_grey;
    logic        n_accept;

    assign n_in_idx  = i_s_axis_tdata[3:0];
    assign n_in_bp   = i_s_axis_tdata[19:4];
    assign n_in_col  = i_s_axis_tdata[67:20];
    assign n_in_grey = i_s_axis_tdata[83:68];

    // the pipeline moves unless a finished result is waiting and not taken
    assign n_en            = !r_vld[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = n_en;
    assign n_accept        = i_s_axis_tvalid && n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= 5'd2;
        end else if (i_cfg_we) begin
            r_points <= i_cfg_wdata;
        end
    end

    // load transfers write straight into the table; out-of-table indexes drop
    always_ff @(posedge i_clk) begin
        if (n_accept && i_s_axis_tuser == gtrc_pkg::OP_LOAD
                && int'(n_in_idx) < MAX_POINTS) begin
            r_bp[IDX_W'(n_in_idx)]  <= n_in_bp;
            r_col[IDX_W'(n_in_idx)] <= n_in_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) r_vld[k] <= 1'b0;
        end else if (n_en) begin
            r_vld[0] <= i_s_axis_tvalid && i_s_axis_tuser == gtrc_pkg::OP_LOOKUP;
            for (int k = 1; k <= LAST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: grey level
    logic [15:0] r_s1_grey;

    always_ff @(posedge i_clk) begin
        if (n_en) r_s1_grey <= n_in_grey;
    end

    // segment search: first segment whose upper breakpoint covers grey,
    // pinned to the last segment in use
    logic [CNT_W-1:0] n_npts;
    logic [IDX_W-1:0] n_seg;
    logic [IDX_W-1:0] n_seg_hi;

    always_comb begin
        if (r_points < 5'd2) begin
            n_npts = CNT_W'(2);
        end else if (int'(r_points) > MAX_POINTS) begin
            n_npts = CNT_W'(MAX_POINTS);
        end else begin
            n_npts = CNT_W'(r_points);
        end
    end

    always_comb begin
        n_seg = '0;
        for (int j = MAX_POINTS - 2; j >= 0; j--) begin
            if (r_s1_grey <= r_bp[j+1] || j == int'(n_npts) - 2) begin
                n_seg = IDX_W'(j);
            end
        end
    end

    assign n_seg_hi = n_seg + IDX_W'(1);

    // stage 2: segment end points and control colours
    logic [15:0] r_s2_grey, r_s2_lo, r_s2_hi;
    logic [47:0] r_s2_ca, r_s2_cb;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s2_grey <= r_s1_grey;
            r_s2_lo   <= r_bp[n_seg];
            r_s2_hi   <= r_bp[n_seg_hi];
            r_s2_ca   <= r_col[n_seg];
            r_s2_cb   <= r_col[n_seg_hi];
        end
    end

    // offset and span; a flat or falling segment divides zero by one
    logic        n_below, n_above, n_flat;
    logic [15:0] n_offset, n_span;

    assign n_below  = r_s2_grey < r_s2_lo;
    assign n_above  = r_s2_grey > r_s2_hi;
    assign n_flat   = !(r_s2_hi > r_s2_lo);
    assign n_offset = (n_below || n_flat) ? 16'h0000 : r_s2_grey - r_s2_lo;
    assign n_span   = n_flat ? 16'h0001 : r_s2_hi - r_s2_lo;

    logic [15:0] n_frac;

    gtrc_frac u_frac (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_offset (n_offset),
        .i_span   (n_span),
        .o_frac   (n_frac)
    );

    // colours and flag follow the divider and channel pipelines
    logic [47:0] r_dly_ca  [0:FLAT-1];
    logic [47:0] r_dly_cb  [0:FLAT-1];
    logic        r_dly_oor [0:FLAT+CLAT-1];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dly_ca[0]  <= r_s2_ca;
            r_dly_cb[0]  <= r_s2_cb;
            r_dly_oor[0] <= n_below || n_above || n_flat;
            for (int k = 1; k < FLAT; k++) begin
                r_dly_ca[k] <= r_dly_ca[k-1];
                r_dly_cb[k] <= r_dly_cb[k-1];
            end
            for (int k = 1; k < FLAT + CLAT; k++) r_dly_oor[k] <= r_dly_oor[k-1];
        end
    end

    // three channel pipelines, red in the low bits
    for (genvar c = 0; c < 3; c++) begin : g_chan
        gtrc_chan u_chan (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_col_a (r_dly_ca[FLAT-1][16*c +: 16]),
            .i_col_b (r_dly_cb[FLAT-1][16*c +: 16]),
            .i_frac  (n_frac),
            .o_col   (o_m_axis_tdata[16*c +: 16])
        );
    end

    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tuser  = r_dly_oor[FLAT+CLAT-1];

endmodule
